FILE: hw/rtl/rlcd_pkg.sv
// ----------------------------------------------------------------------------
// rlcd_pkg
// Shared constants, command types and the run flush helper of the
// run-length codec with decimal repeat counts.
// ----------------------------------------------------------------------------
package rlcd_pkg;

  localparam int MAX_RUN      = 64;
  localparam int LEN_W        = 7;
  localparam int REPS_W       = $clog2(MAX_RUN + 1);
  localparam int CNT_W        = $clog2(MAX_RUN + 2);
  localparam int POS_W        = REPS_W + 1;
  localparam int DECIMAL_BASE = 10;
  localparam int QUEUE_DEPTH  = 4;
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int TENTH_MUL    = 205;
  localparam int TENTH_SHIFT  = 11;

  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  localparam logic [1:0] NDIG_NONE = 2'd0;
  localparam logic [1:0] NDIG_ONE  = 2'd1;
  localparam logic [1:0] NDIG_TWO  = 2'd2;

  // One output segment: optional decimal digits, then the symbol repeated.
  typedef struct packed {
    logic              v;
    logic [7:0]        sym;
    logic [1:0]        ndig;
    logic [3:0]        tens;
    logic [3:0]        units;
    logic [REPS_W-1:0] reps;
    logic              clip;
  } seg_t;

  // All results caused by one input item.
  typedef struct packed {
    seg_t a;
    seg_t b;
    logic fin;
  } cmd_t;

  function automatic seg_t flush_seg(input logic [7:0] sym, input logic [LEN_W-1:0] len);
    logic [LEN_W+7:0] prod;
    logic [3:0]       tens;
    logic [LEN_W-1:0] tens10;
    seg_t             s;
    prod   = {8'b0, len} * (LEN_W + 8)'(TENTH_MUL);
    tens   = 4'(prod >> TENTH_SHIFT);
    tens10 = LEN_W'(tens) * LEN_W'(DECIMAL_BASE);
    s      = '0;
    s.v    = 1'b1;
    s.sym  = sym;
    s.tens = tens;
    s.units = 4'(len - tens10);
    if (len <= LEN_W'(2)) begin
      s.ndig = NDIG_NONE;
      s.reps = REPS_W'(len);
    end else begin
      s.ndig = (len >= LEN_W'(DECIMAL_BASE)) ? NDIG_TWO : NDIG_ONE;
      s.reps = REPS_W'(1);
    end
    return s;
  endfunction

endpackage

FILE: hw/rtl/rlcd_ifs.sv
// ----------------------------------------------------------------------------
// rlcd_ifs
// Valid/ready channels of the codec: input characters and result beats.
// ----------------------------------------------------------------------------
interface rlcd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source(output valid, mode, in_byte, end_of_string, input ready);
  modport sink(input valid, mode, in_byte, end_of_string, output ready);
endinterface

interface rlcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       string_done;
  logic       count_clipped;

  modport source(output valid, out_byte, last_of_run, string_done, count_clipped,
                 input ready);
  modport sink(input valid, out_byte, last_of_run, string_done, count_clipped,
               output ready);
endinterface

FILE: hw/rtl/rlcd_front.sv
// ----------------------------------------------------------------------------
// rlcd_front
// Accepts characters, tracks the encode run and the decode count, and turns
// every item that causes output into one command for the queue.
// ----------------------------------------------------------------------------
module rlcd_front (
  input  logic          clk,
  input  logic          rst,
  rlcd_in_if.sink       item,
  input  logic          full,
  output logic          push,
  output rlcd_pkg::cmd_t cmd
);
  import rlcd_pkg::*;

  logic [7:0]       run_symbol, run_symbol_next;
  logic [LEN_W-1:0] run_length, run_length_next;
  logic [CNT_W-1:0] repeat_count, repeat_count_next;
  logic             run_open, run_open_next;
  logic             count_seen, count_seen_next;

  logic             accept;
  logic [7:0]       sym1;
  logic [LEN_W-1:0] len1;
  logic [CNT_W+3:0] acc10;
  logic [CNT_W-1:0] times;
  logic             clip;
  logic             is_digit;
  seg_t             seg_a, seg_b;

  assign item.ready = !full;
  assign accept     = item.valid && !full;
  assign is_digit   = (item.in_byte >= DIGIT_ZERO) && (item.in_byte <= DIGIT_NINE);

  always_comb begin
    run_symbol_next   = run_symbol;
    run_length_next   = run_length;
    repeat_count_next = repeat_count;
    run_open_next     = run_open;
    count_seen_next   = count_seen;
    seg_a = '0;
    seg_b = '0;
    sym1  = run_symbol;
    len1  = run_length;
    acc10 = '0;
    times = '0;
    clip  = 1'b0;
    if (!item.mode) begin
      repeat_count_next = '0;
      count_seen_next   = 1'b0;
      if (run_open && (item.in_byte == run_symbol)) begin
        len1 = run_length + LEN_W'(1);
        sym1 = run_symbol;
      end else begin
        len1 = LEN_W'(1);
        sym1 = item.in_byte;
        if (run_open) begin
          seg_a = flush_seg(run_symbol, run_length);
        end
      end
      if ((len1 >= LEN_W'(MAX_RUN)) || item.end_of_string) begin
        seg_b           = flush_seg(sym1, len1);
        run_open_next   = 1'b0;
        run_symbol_next = '0;
        run_length_next = '0;
      end else begin
        run_open_next   = 1'b1;
        run_symbol_next = sym1;
        run_length_next = len1;
      end
    end else begin
      run_open_next   = 1'b0;
      run_symbol_next = '0;
      run_length_next = '0;
      if (is_digit) begin
        acc10 = {4'b0, repeat_count} * (CNT_W + 4)'(DECIMAL_BASE)
              + (CNT_W + 4)'(item.in_byte - DIGIT_ZERO);
        if (acc10 > (CNT_W + 4)'(MAX_RUN)) begin
          repeat_count_next = CNT_W'(MAX_RUN + 1);
        end else begin
          repeat_count_next = CNT_W'(acc10);
        end
        count_seen_next = 1'b1;
      end else begin
        times = count_seen ? repeat_count : CNT_W'(1);
        clip  = times > CNT_W'(MAX_RUN);
        if (clip) begin
          times = CNT_W'(MAX_RUN);
        end
        if (times != '0) begin
          seg_a.v    = 1'b1;
          seg_a.sym  = item.in_byte;
          seg_a.reps = REPS_W'(times);
          seg_a.clip = clip;
        end
        repeat_count_next = '0;
        count_seen_next   = 1'b0;
      end
      if (item.end_of_string) begin
        repeat_count_next = '0;
        count_seen_next   = 1'b0;
      end
    end
  end

  always_comb begin
    cmd.fin = item.end_of_string;
    if (seg_a.v) begin
      cmd.a = seg_a;
      cmd.b = seg_b;
    end else begin
      cmd.a = seg_b;
      cmd.b = '0;
    end
  end

  assign push = accept && cmd.a.v;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_symbol   <= '0;
      run_length   <= '0;
      repeat_count <= '0;
      run_open     <= 1'b0;
      count_seen   <= 1'b0;
    end else if (accept) begin
      run_symbol   <= run_symbol_next;
      run_length   <= run_length_next;
      repeat_count <= repeat_count_next;
      run_open     <= run_open_next;
      count_seen   <= count_seen_next;
    end
  end

endmodule

FILE: hw/rtl/rlcd_queue.sv
// ----------------------------------------------------------------------------
// rlcd_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module rlcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rlcd_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           pop,
  output rlcd_pkg::cmd_t rd_data,
  output logic           empty
);
  import rlcd_pkg::*;

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign full    = fill == (PTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (PTR_W + 1)'(1);
        2'b01:   fill <= fill - (PTR_W + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rlcd_back.sv
// ----------------------------------------------------------------------------
// rlcd_back
// Expands the head command into result beats through an output register, one
// beat a cycle while the result side is not stalled.
// ----------------------------------------------------------------------------
module rlcd_back (
  input  logic           clk,
  input  logic           rst,
  input  rlcd_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  rlcd_out_if.source     result
);
  import rlcd_pkg::*;

  logic             seg_sel;
  logic [POS_W-1:0] pos;

  seg_t             cur;
  logic [POS_W-1:0] total;
  logic [3:0]       digit;
  logic [7:0]       beat_byte;
  logic             seg_last;
  logic             entry_last;
  logic             out_free;
  logic             step;

  assign cur   = seg_sel ? head.b : head.a;
  assign total = POS_W'(cur.ndig) + POS_W'(cur.reps);

  always_comb begin
    digit     = cur.units;
    beat_byte = cur.sym;
    if (pos < POS_W'(cur.ndig)) begin
      if ((cur.ndig == NDIG_TWO) && (pos == '0)) begin
        digit = cur.tens;
      end
      beat_byte = DIGIT_ZERO + {4'b0, digit};
    end
  end

  assign seg_last   = pos == (total - POS_W'(1));
  assign entry_last = seg_last && (seg_sel || !head.b.v);
  assign out_free   = !result.valid || result.ready;
  assign step       = !empty && out_free;
  assign pop        = step && entry_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_sel      <= 1'b0;
      pos          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (step) begin
        result.valid         <= 1'b1;
        result.out_byte      <= beat_byte;
        result.count_clipped <= cur.clip;
        result.last_of_run   <= entry_last;
        result.string_done   <= entry_last && head.fin;
        if (seg_last) begin
          pos     <= '0;
          seg_sel <= !entry_last;
        end else begin
          pos <= pos + POS_W'(1);
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/run_length_codec_decimal_unit.sv
// ----------------------------------------------------------------------------
// run_length_codec_decimal_unit
// Throughput: one item a cycle while the four-entry command queue has room;
// the back end sends one beat a cycle while the result side takes them, and
// a command leaves the queue only with its last beat (up to MAX_RUN beats
// for a decoded repeat).
// Reset: synchronous; clears run, count, queue and output register.
// ----------------------------------------------------------------------------
module run_length_codec_decimal_unit (
  input  logic       clk,
  input  logic       rst,
  rlcd_in_if.sink    item,
  rlcd_out_if.source result
);
  import rlcd_pkg::*;

  cmd_t wr_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  rlcd_front u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .full (full),
    .push (push),
    .cmd  (wr_cmd)
  );

  rlcd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_cmd),
    .full    (full),
    .pop     (pop),
    .rd_data (head),
    .empty   (empty)
  );

  rlcd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

FILE: hw/rtl/rlcd_checker.sv
// ----------------------------------------------------------------------------
// rlcd_port_checks
// Port-level checks of the codec, bound to the top level.
// ----------------------------------------------------------------------------
module rlcd_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       string_done,
  input logic       count_clipped
);
  import rlcd_pkg::*;

  a_no_beat_after_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat valid right after reset");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && string_done) |-> last_of_run)
    else $error("string_done on a beat that is not the last of its item");

  a_clip_not_digit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && count_clipped) |-> ((out_byte < DIGIT_ZERO) || (out_byte > DIGIT_NINE)))
    else $error("clipped repeat carries a digit");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(out_byte) && $stable(last_of_run)
       && $stable(string_done) && $stable(count_clipped)))
    else $error("stalled result beat changed");

endmodule

bind run_length_codec_decimal_unit rlcd_port_checks u_rlcd_port_checks (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .out_byte      (result.out_byte),
  .last_of_run   (result.last_of_run),
  .string_done   (result.string_done),
  .count_clipped (result.count_clipped)
);

FILE: bench/rlcd_checker.sv
// ----------------------------------------------------------------------------
// rlcd_checker
// Watches both channels of the run-length codec, predicts the result beats of
// every accepted character from its own copy of the run and count state, and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rlcd_checker
  import rlcd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rlcd_in_if   in_ch,
  rlcd_out_if  out_ch,
  output int   fail_count,
  output int   pending,
  output int   beat_total,
  output int   clipped_total
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_done;
    logic       count_clipped;
  } beat_t;

  beat_t            expected_beats[$];
  beat_t            head;
  logic [7:0]       run_sym;
  logic [LEN_W-1:0] run_len;
  logic [16:0]      rep_count;
  logic             run_open;
  logic             count_seen;
  int               mismatches;
  int               beats;
  int               clipped;

  function automatic void push_beat(input logic [7:0] b, input logic clip);
    beat_t e;
    e = '{out_byte: b, last_of_run: 1'b0, string_done: 1'b0, count_clipped: clip};
    expected_beats.push_back(e);
  endfunction

  function automatic void emit_run();
    int len;
    len = int'(run_len);
    if (len == 0) return;
    if (len <= 2) begin
      repeat (len) push_beat(run_sym, 1'b0);
      return;
    end
    if (len >= 100) push_beat(DIGIT_ZERO + 8'(len / 100), 1'b0);
    if (len >= DECIMAL_BASE)
      push_beat(DIGIT_ZERO + 8'((len / DECIMAL_BASE) % DECIMAL_BASE), 1'b0);
    push_beat(DIGIT_ZERO + 8'(len % DECIMAL_BASE), 1'b0);
    push_beat(run_sym, 1'b0);
  endfunction

  function automatic void clear_run();
    run_sym  = '0;
    run_len  = '0;
    run_open = 1'b0;
  endfunction

  function automatic void clear_count();
    rep_count  = '0;
    count_seen = 1'b0;
  endfunction

  function automatic void predict_beats(input logic decoding, input logic [7:0] b,
                                        input logic eos);
    int          first;
    int          times;
    logic        clip;
    logic [16:0] acc;
    beat_t       tail;
    first = expected_beats.size();
    if (!decoding) begin
      clear_count();
      if (run_open && b == run_sym) begin
        run_len = run_len + 1'b1;
      end else begin
        if (run_open) emit_run();
        run_sym  = b;
        run_len  = LEN_W'(1);
        run_open = 1'b1;
      end
      if (int'(run_len) >= MAX_RUN) begin
        emit_run();
        clear_run();
      end
      if (eos) begin
        if (run_open) emit_run();
        clear_run();
      end
    end else begin
      clear_run();
      if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
        acc = rep_count * 17'(DECIMAL_BASE) + 17'(b - DIGIT_ZERO);
        if (acc > 17'(MAX_RUN)) acc = 17'(MAX_RUN + 1);
        rep_count  = acc;
        count_seen = 1'b1;
      end else begin
        times = count_seen ? int'(rep_count) : 1;
        clip  = (times > MAX_RUN);
        if (clip) times = MAX_RUN;
        repeat (times) push_beat(b, clip);
        clear_count();
      end
      if (eos) clear_count();
    end
    if (expected_beats.size() > first) begin
      tail = expected_beats.pop_back();
      tail.last_of_run = 1'b1;
      tail.string_done = eos;
      expected_beats.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_beats.delete();
      clear_run();
      clear_count();
      mismatches = 0;
      beats      = 0;
      clipped    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_beats(in_ch.mode, in_ch.in_byte, in_ch.end_of_string);
      if (out_ch.valid && out_ch.ready) begin
        beats++;
        if (out_ch.count_clipped === 1'b1) clipped++;
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: out_byte 0x%02h", out_ch.out_byte);
          mismatches++;
        end else begin
          head = expected_beats.pop_front();
          if (out_ch.out_byte !== head.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", head.out_byte, out_ch.out_byte);
            mismatches++;
          end
          if (out_ch.last_of_run !== head.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", head.last_of_run,
                   out_ch.last_of_run);
            mismatches++;
          end
          if (out_ch.string_done !== head.string_done) begin
            $error("string_done: expected %0b, got %0b", head.string_done,
                   out_ch.string_done);
            mismatches++;
          end
          if (out_ch.count_clipped !== head.count_clipped) begin
            $error("count_clipped: expected %0b, got %0b", head.count_clipped,
                   out_ch.count_clipped);
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending       <= expected_beats.size();
    beat_total    <= beats;
    clipped_total <= clipped;
  end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the run-length codec with directed corner strings and then random
// encode, decode and mixed-mode strings, with random gaps on the input side
// and random stalls on the result side; a checker beside the block predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
  import rlcd_pkg::*;

  localparam int   CLK_PERIOD    = 12;
  localparam int   RESET_CYCLES  = 8;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   ITEM_TARGET   = 450;
  localparam int   LONG_HOLD     = 300;
  localparam int   LIMIT_CYCLES  = 4000000;
  localparam logic MODE_ENCODE   = 1'b0;
  localparam logic MODE_DECODE   = 1'b1;

  logic clk = 1'b0;
  logic rst;
  bit   gapless;
  bit   hold_off_req;
  bit   drained;
  int   chars_sent;
  int   enc_strings;
  int   dec_strings;
  int   mixed_strings;
  int   fail_count;
  int   pending;
  int   beat_total;
  int   clipped_total;

  rlcd_in_if  in_ch ();
  rlcd_out_if out_ch ();

  run_length_codec_decimal_unit uut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch)
  );

  rlcd_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .beat_total    (beat_total),
    .clipped_total (clipped_total)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (gapless || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] pick_any_symbol();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'($urandom_range(8'h61, 8'h63));
    if (r < 60) return DIGIT_ZERO + 8'($urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_plain_symbol();
    logic [7:0] b;
    do begin
      if ($urandom_range(3) == 0) b = 8'($urandom_range(8'h61, 8'h64));
      else b = 8'($urandom_range(255));
    end while (b >= DIGIT_ZERO && b <= DIGIT_NINE);
    return b;
  endfunction

  task automatic send_char(input logic m, input logic [7:0] b, input logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= m;
    in_ch.in_byte       <= b;
    in_ch.end_of_string <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_count(input int value, input int ndig, input logic eos_on_last);
    int p;
    int div;
    div = 1;
    for (p = 1; p < ndig; p++) div *= DECIMAL_BASE;
    for (p = 0; p < ndig; p++) begin
      send_char(MODE_DECODE, DIGIT_ZERO + 8'((value / div) % DECIMAL_BASE),
                eos_on_last && p == ndig - 1);
      div /= DECIMAL_BASE;
    end
  endtask

  task automatic encode_string();
    int nruns;
    int len;
    int i;
    int k;
    int r;
    logic [7:0] sym;
    nruns = $urandom_range(1, 6);
    for (i = 0; i < nruns; i++) begin
      sym = pick_any_symbol();
      r   = $urandom_range(99);
      if (r < 50) len = $urandom_range(1, 2);
      else if (r < 80) len = $urandom_range(3, 9);
      else if (r < 95) len = $urandom_range(10, 30);
      else len = $urandom_range(31, 66);
      for (k = 0; k < len; k++)
        send_char(MODE_ENCODE, sym, i == nruns - 1 && k == len - 1);
    end
    enc_strings++;
  endtask

  task automatic decode_string(input int ngroups);
    int   g;
    int   r;
    int   value;
    int   ndig;
    logic trailing;
    trailing = ($urandom_range(9) == 0);
    for (g = 0; g < ngroups; g++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        value = 0;
        ndig  = 0;
      end else if (r < 60) begin
        value = $urandom_range(1, 9);
        ndig  = 1;
      end else if (r < 78) begin
        value = $urandom_range(10, 99);
        ndig  = 2;
      end else if (r < 85) begin
        value = 0;
        ndig  = $urandom_range(1, 2);
      end else if (r < 91) begin
        value = $urandom_range(1, 9);
        ndig  = 2;
      end else begin
        value = $urandom_range(100, 99999);
        ndig  = (value >= 10000) ? 5 : (value >= 1000) ? 4 : 3;
      end
      send_count(value, ndig, 1'b0);
      send_char(MODE_DECODE, pick_plain_symbol(), g == ngroups - 1 && !trailing);
    end
    if (trailing) send_count($urandom_range(99), $urandom_range(1, 2), 1'b1);
    dec_strings++;
  endtask

  task automatic mixed_string();
    int   n;
    int   k;
    logic m;
    logic eos_last;
    n        = $urandom_range(2, 10);
    m        = 1'($urandom_range(1));
    eos_last = ($urandom_range(4) != 0);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 30) m = ~m;
      send_char(m, pick_any_symbol(), k == n - 1 && eos_last);
    end
    mixed_strings++;
  endtask

  initial begin
    int n;
    logic r;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        r = 1'b0;
        n = LONG_HOLD;
      end else begin
        case ($urandom_range(99)) inside
          [0:9]:   begin r = 1'b1; n = $urandom_range(30, 80); end
          [10:64]: begin r = 1'b1; n = $urandom_range(1, 8);   end
          [65:92]: begin r = 1'b0; n = $urandom_range(1, 3);   end
          default: begin r = 1'b0; n = $urandom_range(10, 40); end
        endcase
      end
      out_ch.ready <= r;
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= MODE_ENCODE;
    in_ch.in_byte       <= '0;
    in_ch.end_of_string <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner strings
    send_char(MODE_ENCODE, 8'h00, 1'b1);
    send_char(MODE_ENCODE, 8'hFF, 1'b0);
    send_char(MODE_ENCODE, 8'hFF, 1'b1);
    repeat (3) send_char(MODE_ENCODE, "a", 1'b0);
    send_char(MODE_ENCODE, "b", 1'b1);
    send_char(MODE_ENCODE, "7", 1'b0);
    send_char(MODE_ENCODE, "7", 1'b0);
    send_char(MODE_ENCODE, "7", 1'b1);
    send_char(MODE_DECODE, "0", 1'b0);
    send_char(MODE_DECODE, "X", 1'b1);
    send_char(MODE_DECODE, "1", 1'b0);
    send_char(MODE_DECODE, "2", 1'b0);
    send_char(MODE_DECODE, "Q", 1'b0);
    send_char(MODE_DECODE, "Z", 1'b1);
    repeat (3) send_char(MODE_DECODE, "9", 1'b0);
    send_char(MODE_DECODE, "R", 1'b1);
    send_char(MODE_DECODE, "5", 1'b1);
    send_char(MODE_DECODE, "3", 1'b0);
    send_char(MODE_ENCODE, "K", 1'b1);
    send_char(MODE_ENCODE, "M", 1'b0);
    send_char(MODE_ENCODE, "M", 1'b0);
    send_char(MODE_DECODE, "N", 1'b1);

    // run past the flush limit
    repeat (MAX_RUN) send_char(MODE_ENCODE, "x", 1'b0);
    send_char(MODE_ENCODE, "x", 1'b1);

    // hold the result side off while the input keeps coming
    hold_off_req = 1'b1;
    decode_string(8);

    while (chars_sent < ITEM_TARGET) begin
      if (!drained && chars_sent >= ITEM_TARGET / 2) begin
        drain();
        drained = 1'b1;
      end
      gapless = ($urandom_range(3) == 0);
      case ($urandom_range(99)) inside
        [0:44]:  encode_string();
        [45:84]: decode_string($urandom_range(1, 5));
        default: mixed_string();
      endcase
    end
    gapless = 1'b0;

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb_top: %0d characters in %0d encode, %0d decode and %0d mixed strings",
             chars_sent, enc_strings, dec_strings, mixed_strings);
    $display("tb_top: %0d result beats checked, %0d of them from clipped counts",
             beat_total, clipped_total);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: run_length_codec_decimal_unit.f
hw/rtl/rlcd_pkg.sv
hw/rtl/rlcd_ifs.sv
hw/rtl/rlcd_front.sv
hw/rtl/rlcd_queue.sv
hw/rtl/rlcd_back.sv
hw/rtl/run_length_codec_decimal_unit.sv
hw/rtl/rlcd_checker.sv
bench/rlcd_checker.sv
bench/tb_top.sv
